>>> sv/utf8_to_utf16_transcoder_core_defines.svh
// Assertion macros shared by the transcoder RTL.
`ifndef UTF8_TO_UTF16_TRANSCODER_CORE_DEFINES_SVH
`define UTF8_TO_UTF16_TRANSCODER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define U8U16_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("u8u16 assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define U8U16_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("u8u16 assertion failed");

`endif

>>> sv/u8u16_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package u8u16_pkg;

    localparam int CP_W     = 31;
    localparam int REM_W    = 3;
    localparam int Q_DEPTH  = 3;
    localparam int CNT_W    = $clog2(Q_DEPTH + 1);

    localparam logic [CP_W-1:0] SURR_LO_CP   = 31'h0000D800;
    localparam logic [CP_W-1:0] SURR_END_CP  = 31'h0000E000;
    localparam logic [CP_W-1:0] SUPP_BASE_CP = 31'h00010000;
    localparam logic [CP_W-1:0] SUPP_MAX_CP  = 31'h0010FFFF;
    localparam logic [15:0]     HI_SURR      = 16'hD800;
    localparam logic [15:0]     LO_SURR      = 16'hDC00;

    typedef enum logic [1:0] {
        ERR_NONE        = 2'd0,
        ERR_TRUNCATED   = 2'd1,
        ERR_UNENCODABLE = 2'd2
    } err_t;

    typedef struct packed {
        logic [15:0] unit;
        err_t        error;
        logic        run_last;
        logic        string_end;
    } result_t;

endpackage

`default_nettype wire

>>> sv/utf8_to_utf16_transcoder_core.sv
`timescale 1ns / 1ps
`default_nettype none
// UTF-8 to UTF-16 transcoder. One byte transaction is accepted per cycle on
// s_ while s_ready is high (s_last marks the last byte of a string); decoded
// UTF-16 units are registered in the result queue and leave on m_ one
// transaction per cycle while m_ready is high. Lead bytes of 1..6 byte forms
// are decoded, trailing bytes only contribute their low six bits. A stray
// continuation byte or a 0xFE/0xFF lead gives unit 0x0000. Surrogate-range
// codepoints or codepoints above 0x10FFFF give one result with m_error = 2,
// a string ending inside a form gives m_error = 1; either way the decoder
// is back to idle. Throughput is one byte per cycle while m_ready stays high;
// a supplementary codepoint emits two units, so the byte after it may be held
// back if the output is already backed up. The rate is set by the three-entry
// result queue: a byte is taken only when at most one result remains queued
// after this cycle's output transaction.
`include "utf8_to_utf16_transcoder_core_defines.svh"

module utf8_to_utf16_transcoder_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_byte,
    input  wire logic        s_last,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [15:0]      m_unit,
    output logic [1:0]       m_error,
    output logic             m_run_last,
    output logic             m_string_end
);
    import u8u16_pkg::*;

    // decoder state
    logic [CP_W-1:0]  cp_reg, cp_next;
    logic [REM_W-1:0] rem_reg, rem_next;

    // result queue, entry 0 drives the m_ ports
    result_t          q_reg [Q_DEPTH];
    result_t          q_next [Q_DEPTH];
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic             s_fire, m_fire;
    logic [CNT_W-1:0] cnt_pop;

    // decode datapath
    logic [REM_W-1:0] rem_dec;
    logic [CP_W-1:0]  cp_dec;
    logic [CP_W-1:0]  b6;
    logic [19:0]      supp_off;
    logic             is_bmp, is_supp;
    logic [1:0]       n_res;
    result_t          r0, r1;

    assign m_fire  = m_valid && m_ready;
    assign cnt_pop = cnt_reg - CNT_W'(m_fire);
    assign s_ready = (cnt_pop <= CNT_W'(1));
    assign s_fire  = s_valid && s_ready;

    assign m_valid      = (cnt_reg != '0);
    assign m_unit       = q_reg[0].unit;
    assign m_error      = q_reg[0].error;
    assign m_run_last   = q_reg[0].run_last;
    assign m_string_end = q_reg[0].string_end;

    // byte decode: lead byte when idle, else merge six payload bits
    always_comb begin
        b6      = {{(CP_W-6){1'b0}}, s_byte[5:0]};
        rem_dec = '0;
        cp_dec  = '0;
        if (rem_reg == '0) begin
            if (s_byte[7] == 1'b0) begin
                cp_dec = {{(CP_W-8){1'b0}}, s_byte};
            end else if (s_byte[7:5] == 3'b110) begin
                cp_dec  = {{(CP_W-5){1'b0}}, s_byte[4:0]} << 6;
                rem_dec = 3'd1;
            end else if (s_byte[7:4] == 4'b1110) begin
                cp_dec  = {{(CP_W-4){1'b0}}, s_byte[3:0]} << 12;
                rem_dec = 3'd2;
            end else if (s_byte[7:3] == 5'b11110) begin
                cp_dec  = {{(CP_W-3){1'b0}}, s_byte[2:0]} << 18;
                rem_dec = 3'd3;
            end else if (s_byte[7:2] == 6'b111110) begin
                cp_dec  = {{(CP_W-2){1'b0}}, s_byte[1:0]} << 24;
                rem_dec = 3'd4;
            end else if (s_byte[7:1] == 7'b1111110) begin
                cp_dec  = {{(CP_W-1){1'b0}}, s_byte[0]} << 30;
                rem_dec = 3'd5;
            end
            // stray continuation or 0xFE/0xFF: codepoint 0, one-byte form
        end else begin
            rem_dec = rem_reg - 3'd1;
            case (rem_dec)
                3'd0:    cp_dec = cp_reg | b6;
                3'd1:    cp_dec = cp_reg | (b6 << 6);
                3'd2:    cp_dec = cp_reg | (b6 << 12);
                3'd3:    cp_dec = cp_reg | (b6 << 18);
                3'd4:    cp_dec = cp_reg | (b6 << 24);
                default: cp_dec = cp_reg;
            endcase
        end
    end

    // codepoint classification and result forming
    always_comb begin
        is_bmp   = (cp_dec < SURR_LO_CP) ||
                   ((cp_dec >= SURR_END_CP) && (cp_dec < SUPP_BASE_CP));
        is_supp  = (cp_dec >= SUPP_BASE_CP) && (cp_dec <= SUPP_MAX_CP);
        supp_off = cp_dec[19:0] - SUPP_BASE_CP[19:0];

        r0       = '{unit: 16'h0000, error: ERR_NONE, run_last: 1'b1,
                     string_end: s_last};
        r1       = r0;
        n_res    = 2'd0;
        cp_next  = cp_reg;
        rem_next = rem_reg;

        if (rem_dec == '0) begin
            cp_next  = '0;
            rem_next = '0;
            n_res    = 2'd1;
            if (is_bmp) begin
                r0.unit = cp_dec[15:0];
            end else if (is_supp) begin
                // surrogate pair: high half never closes the byte
                n_res         = 2'd2;
                r0.unit       = HI_SURR | {6'd0, supp_off[19:10]};
                r0.run_last   = 1'b0;
                r0.string_end = 1'b0;
                r1.unit       = LO_SURR | {6'd0, supp_off[9:0]};
            end else begin
                r0.error = ERR_UNENCODABLE;
            end
        end else if (s_last) begin
            cp_next       = '0;
            rem_next      = '0;
            n_res         = 2'd1;
            r0.error      = ERR_TRUNCATED;
            r0.string_end = 1'b1;
        end else begin
            cp_next  = cp_dec;
            rem_next = rem_dec;
        end
    end

    // queue: shift out on an output transaction, append new results behind
    always_comb begin
        result_t sh [Q_DEPTH];
        sh[0] = m_fire ? q_reg[1] : q_reg[0];
        sh[1] = m_fire ? q_reg[2] : q_reg[1];
        sh[2] = q_reg[2];
        cnt_next = cnt_pop;
        for (int i = 0; i < Q_DEPTH; i++) begin
            q_next[i] = sh[i];
            if (s_fire) begin
                if ((CNT_W'(i) == cnt_pop) && (n_res != 2'd0)) begin
                    q_next[i] = r0;
                end else if ((CNT_W'(i) == cnt_pop + CNT_W'(1)) && (n_res == 2'd2)) begin
                    q_next[i] = r1;
                end
            end
        end
        if (s_fire) begin
            cnt_next = cnt_pop + CNT_W'(n_res);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cp_reg  <= '0;
            rem_reg <= '0;
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (s_fire) begin
                cp_reg  <= cp_next;
                rem_reg <= rem_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < Q_DEPTH; i++) begin
            q_reg[i] <= q_next[i];
        end
    end

    // a high surrogate never closes its byte or the string
    `U8U16_ASSERT_SAME(a_hi_surr_not_last, aclk, aresetn,
        m_valid && (m_unit[15:10] == 6'b110110), !m_run_last && !m_string_end)
    // error results carry a zero unit and close their byte
    `U8U16_ASSERT_SAME(a_err_shape, aclk, aresetn,
        m_valid && (m_error != ERR_NONE), (m_unit == 16'h0000) && m_run_last)
    // a string end always leaves the decoder idle
    `U8U16_ASSERT_NEXT(a_last_idle, aclk, aresetn,
        s_valid && s_ready && s_last, rem_reg == '0)
    // the queue never overflows on an accepted byte
    `U8U16_ASSERT_SAME(a_no_overflow, aclk, aresetn,
        s_valid && s_ready, cnt_pop <= CNT_W'(1))

endmodule

`default_nettype wire

>>> sim/tb_utf8_to_utf16_transcoder_core.sv
`timescale 1ns / 1ps

module tb_utf8_to_utf16_transcoder_core;
    import u8u16_pkg::*;

    localparam int PHASE_BYTES  = 560;
    localparam int LONG_STALL   = 300;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 20;

    // Directed bytes as {last, byte}
    localparam int N_DIRECTED = 29;
    localparam logic [8:0] DIRECTED [N_DIRECTED] = '{
        9'h000, 9'h07F,                          // ASCII extremes
        9'h0C2, 9'h080,                          // two-byte form
        9'h0ED, 9'h0A0, 9'h180,                  // U+D800, unencodable, string end
        9'h0F4, 9'h08F, 9'h0BF, 9'h1BF,          // U+10FFFF, pair, string end
        9'h080, 9'h0FE, 9'h1FF,                  // stray bytes give unit 0
        9'h0E2, 9'h182,                          // string ends inside a form
        9'h0C3, 9'h0C3,                          // lead-looking continuation
        9'h0F8, 9'h088, 9'h080, 9'h080, 9'h080,  // five-byte form above range
        9'h0FD, 9'h0BF, 9'h0BF, 9'h0BF, 9'h0BF, 9'h1BF  // 31-bit maximum
    };

    class transcode_scoreboard;
        logic [CP_W-1:0]  partial_cp;
        logic [REM_W-1:0] owed;
        result_t          expected_units[$];
        int mismatches;
        int units_checked;
        int pairs;
        int truncated;
        int unencodable;

        function new();
            partial_cp = '0;
            owed       = '0;
        endfunction

        function void push_unit(logic [15:0] u, err_t e, logic rl, logic se);
            result_t r;
            r.unit       = u;
            r.error      = e;
            r.run_last   = rl;
            r.string_end = se;
            expected_units = {expected_units, r};
        endfunction

        // Decode one accepted byte and queue the UTF-16 units it produces.
        function void decode_byte(logic [7:0] b, logic last);
            logic [CP_W-1:0]  cp;
            logic [REM_W-1:0] rem;
            logic [19:0]      off;
            if (owed == 0) begin
                casez (b)
                    8'b0???????: begin cp = CP_W'(b);             rem = 3'd0; end
                    8'b110?????: begin cp = CP_W'(b[4:0]) << 6;   rem = 3'd1; end
                    8'b1110????: begin cp = CP_W'(b[3:0]) << 12;  rem = 3'd2; end
                    8'b11110???: begin cp = CP_W'(b[2:0]) << 18;  rem = 3'd3; end
                    8'b111110??: begin cp = CP_W'(b[1:0]) << 24;  rem = 3'd4; end
                    8'b1111110?: begin cp = CP_W'(b[0]) << 30;    rem = 3'd5; end
                    default:     begin cp = '0;                   rem = 3'd0; end
                endcase
            end else begin
                // any byte continues an open form, only its low six bits count
                rem = owed - 3'd1;
                cp  = partial_cp | (CP_W'(b[5:0]) << (6 * rem));
            end

            if (rem == 0) begin
                partial_cp = '0;
                owed       = '0;
                if (cp < SURR_LO_CP || (cp >= SURR_END_CP && cp < SUPP_BASE_CP)) begin
                    push_unit(cp[15:0], ERR_NONE, 1'b1, last);
                end else if (cp >= SUPP_BASE_CP && cp <= SUPP_MAX_CP) begin
                    off = 20'(cp - SUPP_BASE_CP);
                    push_unit(HI_SURR | 16'(off[19:10]), ERR_NONE, 1'b0, 1'b0);
                    push_unit(LO_SURR | 16'(off[9:0]), ERR_NONE, 1'b1, last);
                    pairs++;
                end else begin
                    push_unit(16'h0000, ERR_UNENCODABLE, 1'b1, last);
                    unencodable++;
                end
            end else if (last) begin
                partial_cp = '0;
                owed       = '0;
                push_unit(16'h0000, ERR_TRUNCATED, 1'b1, 1'b1);
                truncated++;
            end else begin
                partial_cp = cp;
                owed       = rem;
            end
        endfunction

        function void check_unit(logic [15:0] u, logic [1:0] e, logic rl, logic se);
            result_t r;
            if (expected_units.size() == 0) begin
                $display("%0t: unexpected result unit=%h error=%0d run_last=%0b end=%0b",
                         $time, u, e, rl, se);
                mismatches++;
                return;
            end
            r = expected_units.pop_front();
            units_checked++;
            if (u !== r.unit || e !== r.error || rl !== r.run_last || se !== r.string_end)
            begin
                $display("%0t: mismatch expected unit=%h error=%0d run_last=%0b end=%0b",
                         $time, r.unit, r.error, r.run_last, r.string_end);
                $display("%0t:          actual   unit=%h error=%0d run_last=%0b end=%0b",
                         $time, u, e, rl, se);
                mismatches++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_byte;
    logic        s_last;
    logic        m_valid;
    logic        m_ready;
    logic [15:0] m_unit;
    logic [1:0]  m_error;
    logic        m_run_last;
    logic        m_string_end;

    transcode_scoreboard sb = new();

    int send_idle_pct;
    int recv_idle_pct;
    bit long_stall_request;
    bit long_stall_done;
    int stall_left;
    int quiet_cycles;
    int bytes_sent;
    int strings_sent;

    utf8_to_utf16_transcoder_core dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_byte       (s_byte),
        .s_last       (s_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_unit       (m_unit),
        .m_error      (m_error),
        .m_run_last   (m_run_last),
        .m_string_end (m_string_end)
    );

    always #5 aclk = ~aclk;

    // Receiver: random backpressure, plus one long hold-off on request.
    always @(posedge aclk) begin
        if (long_stall_request && !long_stall_done) begin
            long_stall_done = 1'b1;
            stall_left      = LONG_STALL;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Result monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_unit(m_unit, m_error, m_run_last, m_string_end);
    end

    // Watchdog: cycles without any transaction on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
                $display("FAILURE");
                $finish;
            end
        end
    end

    // One byte transaction; returns after the accepting edge.
    task automatic send_byte(input logic [7:0] data, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_byte  <= data;
        s_last  <= last;
        do @(posedge aclk); while (!s_ready);
        sb.decode_byte(data, last);
        bytes_sent++;
    endtask

    // Mostly well-formed forms with random payload; some noise, stray
    // bytes, bad continuations and strings cut inside a form.
    task automatic send_random_string();
        logic [7:0] pending_bytes[$];
        logic [7:0] lead;
        int forms;
        int sel;
        int n;
        forms = $urandom_range(1, 6);
        for (int i = 0; i < forms; i++) begin
            sel = $urandom_range(0, 99);
            n   = 1;
            if (sel < 25) begin
                lead = 8'($urandom_range(0, 127));
            end else if (sel < 40) begin
                lead = 8'hC0 | 8'($urandom_range(0, 31));
                n    = 2;
            end else if (sel < 55) begin
                // ED lead lands in the surrogate range half the time
                lead = ($urandom_range(0, 3) == 0) ? 8'hED : (8'hE0 | 8'($urandom_range(0, 15)));
                n    = 3;
            end else if (sel < 72) begin
                // mostly F0..F4 so the 0x10FFFF boundary gets hit often
                lead = 8'hF0 | 8'($urandom_range(0, ($urandom_range(0, 4) == 0) ? 7 : 4));
                n    = 4;
            end else if (sel < 80) begin
                n    = 5 + $urandom_range(0, 1);
                lead = (n == 5) ? (8'hF8 | 8'($urandom_range(0, 3)))
                                : (8'hFC | 8'($urandom_range(0, 1)));
            end else if (sel < 90) begin
                lead = ($urandom_range(0, 3) == 0) ? (8'hFE | 8'($urandom_range(0, 1)))
                                                   : (8'h80 | 8'($urandom_range(0, 63)));
            end else begin
                lead = 8'($urandom_range(0, 255));
                n    = $urandom_range(1, 6);
            end
            if (i == forms - 1 && n > 1 && $urandom_range(0, 99) < 15)
                n = $urandom_range(1, n - 1);
            pending_bytes = {pending_bytes, lead};
            for (int k = 1; k < n; k++) begin
                pending_bytes = {pending_bytes,
                                 (($urandom_range(0, 19) == 0)
                                  ? 8'($urandom_range(0, 255))
                                  : (8'h80 | 8'($urandom_range(0, 63))))};
            end
        end
        foreach (pending_bytes[k])
            send_byte(pending_bytes[k], k == pending_bytes.size() - 1);
        strings_sent++;
    endtask

    initial begin
        int phase_start;
        aresetn            <= 1'b0;
        s_valid            <= 1'b0;
        s_byte             <= 8'h00;
        s_last             <= 1'b0;
        m_ready            <= 1'b0;
        send_idle_pct      = 10;
        recv_idle_pct      = 85;
        long_stall_request = 1'b0;
        long_stall_done    = 1'b0;
        stall_left         = 0;
        quiet_cycles       = 0;
        bytes_sent         = 0;
        strings_sent       = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (DIRECTED[i])
            send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);

        // phase 0: slow receiver, phase 1: slow sender, phase 2: full rate
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 1) ? 85 : ((phase == 0) ? 10 : 0);
            recv_idle_pct = (phase == 1) ? 10 : ((phase == 0) ? 85 : 0);
            // full-rate phase opens with a long output hold-off to fill the block
            if (phase == 2)
                long_stall_request = 1'b1;
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES)
                send_random_string();
        end
        s_valid <= 1'b0;

        while (sb.expected_units.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d bytes in %0d strings; checked %0d UTF-16 units.",
                 bytes_sent, strings_sent, sb.units_checked);
        $display("Seen %0d surrogate pairs, %0d truncated and %0d unencodable errors.",
                 sb.pairs, sb.truncated, sb.unencodable);
        if (sb.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
